[rtl/double_ended_queue_core_macros.svh]
// assertion helpers for the queue core
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define DQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// antecedent in this cycle, consequent in the next
`define DQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dq_pkg.sv]
package dq_pkg;

   localparam int DQ_CAPACITY   = 1024;
   localparam int DQ_WORD_WIDTH = 64;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 64;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_PUSH_BACK  = 3'd0;
   localparam kind_type KIND_PUSH_FRONT = 3'd1;
   localparam kind_type KIND_POP_BACK   = 3'd2;
   localparam kind_type KIND_POP_FRONT  = 3'd3;
   localparam kind_type KIND_READ       = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_RSVD  = 2'd3;

endpackage

[rtl/dq_ram.sv]
module dq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/double_ended_queue_core.sv]
// Bounded double-ended queue of words held in a circular buffer.
//
// Request channel: drive req_kind, req_push_value and req_position with
// start high; the beat is taken on any edge where busy is low. busy never
// rises in this design, so a new request may be issued every cycle.
// Kinds: push back, push front, pop back, pop front, read at a position
// counted from the front.
//
// Result channel: exactly one result beat per request, shown for one cycle
// with rsp_valid high, in the cycle after the request is taken. It carries the
// word popped or read (zero on a push or an error), a status (ok, empty or
// out of range, full) and the entry count after the request.
// Throughput is one request per clock: the front pointer and count update at the
// accepting edge, and the single storage RAM takes the write or the read in
// that same cycle; its read port is registered.
// The receiver cannot stall; results must be taken as they appear.
//
// Reset empties the queue (pointer and count cleared); stored words are not
// cleared and are never read before being written.
module double_ended_queue_core
   import dq_pkg::*;
#(
   parameter int CAPACITY   = DQ_CAPACITY,
   parameter int WORD_WIDTH = DQ_WORD_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [VALUE_W-1:0]  req_push_value,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

`include "double_ended_queue_core_macros.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_sel_ff, rsp_sel_in;
   status_type            rsp_status_ff, status_in;
   logic [CW-1:0]         rsp_count_ff;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  pos_ok;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;
   logic [WORD_WIDTH-1:0] wr_data;
   logic                  is_push;

   // circular add; both operands stay below CAPACITY
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] offs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (AW+1)'(CAPACITY)) begin
         sum = sum - (AW+1)'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_ok  = (PW'(req_position) < PW'(count_ff));
   assign wr_data = WORD_WIDTH'(req_push_value);
   assign is_push = (req_kind == KIND_PUSH_BACK) || (req_kind == KIND_PUSH_FRONT);

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      status_in  = ST_OK;
      rsp_sel_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = wrap_add(front_ff, count_ff[AW-1:0]);
      rd_addr    = front_ff;
      if (accept) begin
         case (req_kind)
            KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  front_in = wrap_add(front_ff, AW'(CAPACITY - 1));
                  wr_addr  = front_in;
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_addr    = wrap_add(front_ff, AW'(count_ff - CW'(1)));
                  rsp_sel_in = 1'b1;
                  count_in   = count_ff - CW'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_addr    = front_ff;
                  front_in   = wrap_add(front_ff, AW'(1));
                  rsp_sel_in = 1'b1;
                  count_in   = count_ff - CW'(1);
               end
            end
            KIND_READ: begin
               if (!pos_ok) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_addr    = wrap_add(front_ff, AW'(req_position));
                  rsp_sel_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   dq_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_sel_ff    <= rsp_sel_in;
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_sel_ff ? VALUE_W'(rd_data) : '0;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = COUNT_W'(rsp_count_ff);

   `DQ_ASSERT(a_count_bound, (count_ff <= CW'(CAPACITY)), "entry count above capacity")
   `DQ_ASSERT(a_front_bound, (AW'(front_ff) < (AW+1)'(CAPACITY)), "front pointer out of range")
   `DQ_ASSERT_NEXT(a_push_grows, accept && is_push && !full, count_ff == CW'($past(count_ff) + CW'(1)), "push did not grow the count")
   `DQ_ASSERT(a_status_legal, (rsp_valid |-> (rsp_status != ST_RSVD)), "reserved status code")
   `DQ_ASSERT(a_error_zero, ((rsp_valid && rsp_status != ST_OK) |-> (rsp_read_value == '0)), "error result with nonzero word")

endmodule
